/* rtl/a64ic_pkg.sv */
// types, class codes and match patterns shared by the instruction classifier
package a64ic_pkg;

    localparam logic [4:0] CLS_B       = 5'd0;
    localparam logic [4:0] CLS_BL      = 5'd1;
    localparam logic [4:0] CLS_BCOND   = 5'd2;
    localparam logic [4:0] CLS_CBZ     = 5'd3;
    localparam logic [4:0] CLS_CBNZ    = 5'd4;
    localparam logic [4:0] CLS_TBZ     = 5'd5;
    localparam logic [4:0] CLS_TBNZ    = 5'd6;
    localparam logic [4:0] CLS_BR      = 5'd7;
    localparam logic [4:0] CLS_BLR     = 5'd8;
    localparam logic [4:0] CLS_RET     = 5'd9;
    localparam logic [4:0] CLS_ADR     = 5'd10;
    localparam logic [4:0] CLS_ADRP    = 5'd11;
    localparam logic [4:0] CLS_LDR_GPR = 5'd12;
    localparam logic [4:0] CLS_LDR_FP  = 5'd13;
    localparam logic [4:0] CLS_MRS     = 5'd14;
    localparam logic [4:0] CLS_MSR     = 5'd15;
    localparam logic [4:0] CLS_SVC     = 5'd16;
    localparam logic [4:0] CLS_OTHER   = 5'd17;

    localparam logic [2:0] KIND_W = 3'd0;
    localparam logic [2:0] KIND_X = 3'd1;
    localparam logic [2:0] KIND_S = 3'd2;

    localparam logic [1:0] BR_OP_BR   = 2'd0;
    localparam logic [1:0] BR_OP_BLR  = 2'd1;
    localparam logic [1:0] BR_OP_RET  = 2'd2;
    localparam logic [1:0] OPC_NONE   = 2'd3;

    localparam logic [31:0] MASK_B     = 32'h7c00_0000;
    localparam logic [31:0] PAT_B      = 32'h1400_0000;
    localparam logic [31:0] MASK_BCOND = 32'hff00_0010;
    localparam logic [31:0] PAT_BCOND  = 32'h5400_0000;
    localparam logic [31:0] MASK_CMPTB = 32'h7e00_0000;
    localparam logic [31:0] PAT_CB     = 32'h3400_0000;
    localparam logic [31:0] PAT_TB     = 32'h3600_0000;
    localparam logic [31:0] MASK_BR    = 32'hff9f_fc1f;
    localparam logic [31:0] PAT_BR     = 32'hd61f_0000;
    localparam logic [31:0] MASK_ADR   = 32'h1f00_0000;
    localparam logic [31:0] PAT_ADR    = 32'h1000_0000;
    localparam logic [31:0] MASK_LDRG  = 32'hbf00_0000;
    localparam logic [31:0] PAT_LDRG   = 32'h1800_0000;
    localparam logic [31:0] MASK_LDRF  = 32'h3f00_0000;
    localparam logic [31:0] PAT_LDRF   = 32'h1c00_0000;
    localparam logic [31:0] MASK_SYS   = 32'hffff_ffe0;
    localparam logic [31:0] PAT_MRS    = 32'hd53b_d040;
    localparam logic [31:0] PAT_MSR    = 32'hd51b_d040;
    localparam logic [31:0] MASK_SVC   = 32'hffe0_001f;
    localparam logic [31:0] PAT_SVC    = 32'hd400_0001;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [63:0] pc;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]  op_class;
        logic [63:0] target_addr;
        logic [3:0]  cond_code;
        logic [2:0]  reg_kind;
        logic [4:0]  reg_primary;
        logic [4:0]  reg_second;
        logic [4:0]  reg_third;
        logic [4:0]  reg_fourth;
        logic [5:0]  bit_index;
        logic [15:0] imm_value;
        logic [1:0]  mem_size_code;
        logic [63:0] next_pc;
    } out_beat_t;

    typedef struct packed {
        logic [4:0]         op_class;
        logic signed [32:0] offset;
        logic               page_base;
        logic               has_target;
        logic [3:0]         cond_code;
        logic [2:0]         reg_kind;
        logic [4:0]         reg_primary;
        logic [4:0]         reg_second;
        logic [4:0]         reg_third;
        logic [4:0]         reg_fourth;
        logic [5:0]         bit_index;
        logic [15:0]        imm_value;
        logic [1:0]         mem_size_code;
    } dec_t;

endpackage

/* rtl/a64ic_front.sv */
// front end: matches the instruction word and extracts its fields and pc-relative offset
module a64ic_front
(
    input  logic [31:0]    instr_word,
    output a64ic_pkg::dec_t dec
);

    logic [31:0]        w;
    logic signed [32:0] off19;

    assign w     = instr_word;
    assign off19 = 33'($signed({w[23:5], 2'b00}));

    always_comb
    begin
        dec = '0;
        priority if ((w & a64ic_pkg::MASK_B) == a64ic_pkg::PAT_B)
        begin
            dec.op_class   = w[31] ? a64ic_pkg::CLS_BL : a64ic_pkg::CLS_B;
            dec.offset     = 33'($signed({w[25:0], 2'b00}));
            dec.has_target = 1'b1;
        end
        else if ((w & a64ic_pkg::MASK_BCOND) == a64ic_pkg::PAT_BCOND)
        begin
            dec.op_class   = a64ic_pkg::CLS_BCOND;
            dec.offset     = off19;
            dec.has_target = 1'b1;
            dec.cond_code  = w[3:0];
        end
        else if ((w & a64ic_pkg::MASK_CMPTB) == a64ic_pkg::PAT_CB)
        begin
            dec.op_class    = w[24] ? a64ic_pkg::CLS_CBNZ : a64ic_pkg::CLS_CBZ;
            dec.offset      = off19;
            dec.has_target  = 1'b1;
            dec.reg_kind    = w[31] ? a64ic_pkg::KIND_X : a64ic_pkg::KIND_W;
            dec.reg_primary = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_CMPTB) == a64ic_pkg::PAT_TB)
        begin
            dec.op_class    = w[24] ? a64ic_pkg::CLS_TBNZ : a64ic_pkg::CLS_TBZ;
            dec.offset      = 33'($signed({w[18:5], 2'b00}));
            dec.has_target  = 1'b1;
            dec.reg_kind    = a64ic_pkg::KIND_X;
            dec.reg_primary = w[4:0];
            dec.bit_index   = {w[31], w[23:19]};
        end
        else if (((w & a64ic_pkg::MASK_BR) == a64ic_pkg::PAT_BR)
                 && (w[22:21] != a64ic_pkg::OPC_NONE))
        begin
            unique case (w[22:21])
                a64ic_pkg::BR_OP_BR:  dec.op_class = a64ic_pkg::CLS_BR;
                a64ic_pkg::BR_OP_BLR: dec.op_class = a64ic_pkg::CLS_BLR;
                default:              dec.op_class = a64ic_pkg::CLS_RET;
            endcase
            dec.reg_kind    = a64ic_pkg::KIND_X;
            dec.reg_primary = w[9:5];
        end
        else if ((w & a64ic_pkg::MASK_ADR) == a64ic_pkg::PAT_ADR)
        begin
            if (w[31])
            begin
                dec.op_class  = a64ic_pkg::CLS_ADRP;
                dec.offset    = $signed({w[23:5], w[30:29], 12'h000});
                dec.page_base = 1'b1;
            end
            else
            begin
                dec.op_class = a64ic_pkg::CLS_ADR;
                dec.offset   = 33'($signed({w[23:5], w[30:29]}));
            end
            dec.has_target  = 1'b1;
            dec.reg_kind    = a64ic_pkg::KIND_X;
            dec.reg_primary = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_LDRG) == a64ic_pkg::PAT_LDRG)
        begin
            dec.op_class      = a64ic_pkg::CLS_LDR_GPR;
            dec.offset        = off19;
            dec.has_target    = 1'b1;
            dec.reg_kind      = w[30] ? a64ic_pkg::KIND_X : a64ic_pkg::KIND_W;
            dec.mem_size_code = {1'b0, w[30]};
            dec.reg_primary   = w[4:0];
        end
        else if (((w & a64ic_pkg::MASK_LDRF) == a64ic_pkg::PAT_LDRF)
                 && (w[31:30] != a64ic_pkg::OPC_NONE))
        begin
            dec.op_class      = a64ic_pkg::CLS_LDR_FP;
            dec.offset        = off19;
            dec.has_target    = 1'b1;
            dec.reg_kind      = a64ic_pkg::KIND_S + {1'b0, w[31:30]};
            dec.mem_size_code = w[31:30];
            dec.reg_primary   = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_SYS) == a64ic_pkg::PAT_MRS)
        begin
            dec.op_class    = a64ic_pkg::CLS_MRS;
            dec.reg_kind    = a64ic_pkg::KIND_X;
            dec.reg_primary = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_SYS) == a64ic_pkg::PAT_MSR)
        begin
            dec.op_class    = a64ic_pkg::CLS_MSR;
            dec.reg_kind    = a64ic_pkg::KIND_X;
            dec.reg_primary = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_SVC) == a64ic_pkg::PAT_SVC)
        begin
            dec.op_class  = a64ic_pkg::CLS_SVC;
            dec.imm_value = w[20:5];
        end
        else
        begin
            dec.op_class    = a64ic_pkg::CLS_OTHER;
            dec.reg_kind    = a64ic_pkg::KIND_X;
            dec.reg_primary = w[4:0];
            dec.reg_second  = w[9:5];
            dec.reg_third   = w[14:10];
            dec.reg_fourth  = w[20:16];
        end
    end

endmodule

/* rtl/a64ic_queue.sv */
// small fifo between the front end and the back end
module a64ic_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/a64ic_back.sv */
// back end: forms target and next pc and holds the result beat in an output register
module a64ic_back
#(
    parameter int ADDR_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  a64ic_pkg::dec_t       dec,
    input  logic [ADDR_WIDTH-1:0] pc,
    output logic                  result_valid,
    input  logic                  result_ready,
    output a64ic_pkg::out_beat_t  result
);

    logic                  valid_reg;
    a64ic_pkg::out_beat_t  result_reg, result_next;
    logic [ADDR_WIDTH-1:0] base;
    logic [ADDR_WIDTH-1:0] target;
    logic [ADDR_WIDTH-1:0] next_pc;

    assign q_ready      = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    assign base    = dec.page_base ? {pc[ADDR_WIDTH-1:12], 12'h000} : pc;
    assign target  = base + ADDR_WIDTH'(dec.offset);
    assign next_pc = pc + ADDR_WIDTH'(4);

    always_comb
    begin
        result_next               = '0;
        result_next.op_class      = dec.op_class;
        result_next.target_addr   = dec.has_target ? 64'(target) : 64'h0;
        result_next.cond_code     = dec.cond_code;
        result_next.reg_kind      = dec.reg_kind;
        result_next.reg_primary   = dec.reg_primary;
        result_next.reg_second    = dec.reg_second;
        result_next.reg_third     = dec.reg_third;
        result_next.reg_fourth    = dec.reg_fourth;
        result_next.bit_index     = dec.bit_index;
        result_next.imm_value     = dec.imm_value;
        result_next.mem_size_code = dec.mem_size_code;
        result_next.next_pc       = 64'(next_pc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_ready)
        begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ready && q_valid)
        begin
            result_reg <= result_next;
        end
    end

endmodule

/* rtl/a64_instruction_classifier_top.sv */
// top level of the a64 instruction classifier
// Classifies one 32-bit A64 instruction word per beat and returns one result beat holding
// its class, decoded fields, pc-relative target and next pc. One instruction is accepted
// every cycle while the queue has room (instr_ready); a result is registered first by the
// write into the front-to-back queue and then in the output register behind the
// target adder. The queue (QUEUE_DEPTH entries) lets input stay open while a result
// waits to be taken. Addresses are computed modulo 2^ADDR_WIDTH and zero-extended
// to 64 bits on the ports.
module a64_instruction_classifier_top
#(
    parameter int ADDR_WIDTH  = 64,
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 instr_valid,
    output logic                 instr_ready,
    input  a64ic_pkg::in_beat_t  instr,
    output logic                 result_valid,
    input  logic                 result_ready,
    output a64ic_pkg::out_beat_t result
);

    localparam int DEC_W = $bits(a64ic_pkg::dec_t);
    localparam int Q_W   = DEC_W + ADDR_WIDTH;

    a64ic_pkg::dec_t       dec_front;
    a64ic_pkg::dec_t       dec_back;
    logic [ADDR_WIDTH-1:0] pc_back;
    logic [Q_W-1:0]        q_wr_data;
    logic [Q_W-1:0]        q_rd_data;
    logic                  q_valid;
    logic                  q_ready;

    a64ic_front u_front
    (
        .instr_word (instr.instr_word),
        .dec        (dec_front)
    );

    assign q_wr_data = {dec_front, instr.pc[ADDR_WIDTH-1:0]};

    a64ic_queue
    #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (instr_valid),
        .wr_ready (instr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_rd_data)
    );

    assign dec_back = a64ic_pkg::dec_t'(q_rd_data[Q_W-1:ADDR_WIDTH]);
    assign pc_back  = q_rd_data[ADDR_WIDTH-1:0];

    a64ic_back
    #(
        .ADDR_WIDTH (ADDR_WIDTH)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .dec          (dec_back),
        .pc           (pc_back),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* tb/tb.sv */
// testbench for the a64 instruction classifier: directed and random words checked beat by beat
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 instr_valid = 1'b0;
    logic                 instr_ready;
    a64ic_pkg::in_beat_t  instr = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    a64ic_pkg::out_beat_t result;

    a64ic_pkg::out_beat_t pending_results[$];
    int        mismatch_count = 0;
    int        beats_sent = 0;
    int        results_checked = 0;
    int        stall_cycles = 0;
    int        class_hits[32];
    bit        steady = 1'b0;
    bit        hold_request = 1'b0;
    int        hold_left = 0;

    a64_instruction_classifier_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_ready  (instr_ready),
        .instr        (instr),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    function automatic a64ic_pkg::out_beat_t decode_instr(logic [31:0] w, logic [63:0] pc);
        a64ic_pkg::out_beat_t r;
        logic [63:0] off19;
        logic [63:0] off21;
        off19 = {{43{w[23]}}, w[23:5], 2'b00};
        off21 = {{43{w[23]}}, w[23:5], w[30:29]};
        r = '0;
        r.op_class = a64ic_pkg::CLS_OTHER;
        r.next_pc = pc + 64'd4;
        if ((w & a64ic_pkg::MASK_B) == a64ic_pkg::PAT_B)
        begin
            r.op_class = w[31] ? a64ic_pkg::CLS_BL : a64ic_pkg::CLS_B;
            r.target_addr = pc + {{36{w[25]}}, w[25:0], 2'b00};
        end
        else if ((w & a64ic_pkg::MASK_BCOND) == a64ic_pkg::PAT_BCOND)
        begin
            r.op_class = a64ic_pkg::CLS_BCOND;
            r.target_addr = pc + off19;
            r.cond_code = w[3:0];
        end
        else if ((w & a64ic_pkg::MASK_CMPTB) == a64ic_pkg::PAT_CB)
        begin
            r.op_class = w[24] ? a64ic_pkg::CLS_CBNZ : a64ic_pkg::CLS_CBZ;
            r.target_addr = pc + off19;
            r.reg_kind = w[31] ? a64ic_pkg::KIND_X : a64ic_pkg::KIND_W;
            r.reg_primary = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_CMPTB) == a64ic_pkg::PAT_TB)
        begin
            r.op_class = w[24] ? a64ic_pkg::CLS_TBNZ : a64ic_pkg::CLS_TBZ;
            r.target_addr = pc + {{48{w[18]}}, w[18:5], 2'b00};
            r.reg_kind = a64ic_pkg::KIND_X;
            r.reg_primary = w[4:0];
            r.bit_index = {w[31], w[23:19]};
        end
        else if ((w & a64ic_pkg::MASK_BR) == a64ic_pkg::PAT_BR
                 && w[22:21] != a64ic_pkg::OPC_NONE)
        begin
            case (w[22:21])
                a64ic_pkg::BR_OP_BR:  r.op_class = a64ic_pkg::CLS_BR;
                a64ic_pkg::BR_OP_BLR: r.op_class = a64ic_pkg::CLS_BLR;
                default:              r.op_class = a64ic_pkg::CLS_RET;
            endcase
            r.reg_kind = a64ic_pkg::KIND_X;
            r.reg_primary = w[9:5];
        end
        else if ((w & a64ic_pkg::MASK_ADR) == a64ic_pkg::PAT_ADR)
        begin
            if (w[31])
            begin
                r.op_class = a64ic_pkg::CLS_ADRP;
                r.target_addr = (pc & ~64'hfff) + (off21 << 12);
            end
            else
            begin
                r.op_class = a64ic_pkg::CLS_ADR;
                r.target_addr = pc + off21;
            end
            r.reg_kind = a64ic_pkg::KIND_X;
            r.reg_primary = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_LDRG) == a64ic_pkg::PAT_LDRG)
        begin
            r.op_class = a64ic_pkg::CLS_LDR_GPR;
            r.target_addr = pc + off19;
            r.reg_kind = w[30] ? a64ic_pkg::KIND_X : a64ic_pkg::KIND_W;
            r.mem_size_code = {1'b0, w[30]};
            r.reg_primary = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_LDRF) == a64ic_pkg::PAT_LDRF
                 && w[31:30] != a64ic_pkg::OPC_NONE)
        begin
            r.op_class = a64ic_pkg::CLS_LDR_FP;
            r.target_addr = pc + off19;
            r.reg_kind = a64ic_pkg::KIND_S + {1'b0, w[31:30]};
            r.mem_size_code = w[31:30];
            r.reg_primary = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_SYS) == a64ic_pkg::PAT_MRS)
        begin
            r.op_class = a64ic_pkg::CLS_MRS;
            r.reg_kind = a64ic_pkg::KIND_X;
            r.reg_primary = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_SYS) == a64ic_pkg::PAT_MSR)
        begin
            r.op_class = a64ic_pkg::CLS_MSR;
            r.reg_kind = a64ic_pkg::KIND_X;
            r.reg_primary = w[4:0];
        end
        else if ((w & a64ic_pkg::MASK_SVC) == a64ic_pkg::PAT_SVC)
        begin
            r.op_class = a64ic_pkg::CLS_SVC;
            r.imm_value = w[20:5];
        end
        else
        begin
            r.reg_kind = a64ic_pkg::KIND_X;
            r.reg_primary = w[4:0];
            r.reg_second = w[9:5];
            r.reg_third = w[14:10];
            r.reg_fourth = w[20:16];
        end
        return r;
    endfunction

    // a class pattern with random free bits, plain noise, or a pattern with one bit flipped
    function automatic logic [31:0] shaped_word();
        logic [31:0] raw;
        logic [31:0] m;
        logic [31:0] p;
        logic [31:0] w;
        int          sel;
        int          idx;
        raw = $urandom;
        sel = $urandom_range(0, 12);
        idx = (sel == 12) ? $urandom_range(0, 10) : sel;
        case (idx)
            0:       begin m = a64ic_pkg::MASK_B;     p = a64ic_pkg::PAT_B;     end
            1:       begin m = a64ic_pkg::MASK_BCOND; p = a64ic_pkg::PAT_BCOND; end
            2:       begin m = a64ic_pkg::MASK_CMPTB; p = a64ic_pkg::PAT_CB;    end
            3:       begin m = a64ic_pkg::MASK_CMPTB; p = a64ic_pkg::PAT_TB;    end
            4:       begin m = a64ic_pkg::MASK_BR;    p = a64ic_pkg::PAT_BR;    end
            5:       begin m = a64ic_pkg::MASK_ADR;   p = a64ic_pkg::PAT_ADR;   end
            6:       begin m = a64ic_pkg::MASK_LDRG;  p = a64ic_pkg::PAT_LDRG;  end
            7:       begin m = a64ic_pkg::MASK_LDRF;  p = a64ic_pkg::PAT_LDRF;  end
            8:       begin m = a64ic_pkg::MASK_SYS;   p = a64ic_pkg::PAT_MRS;   end
            9:       begin m = a64ic_pkg::MASK_SYS;   p = a64ic_pkg::PAT_MSR;   end
            10:      begin m = a64ic_pkg::MASK_SVC;   p = a64ic_pkg::PAT_SVC;   end
            default: begin m = '0;                    p = '0;                   end
        endcase
        w = (raw & ~m) | p;
        if (sel == 12)
            w[5'($urandom_range(0, 31))] ^= 1'b1;
        return w;
    endfunction

    function automatic logic [63:0] shaped_pc();
        case ($urandom_range(0, 3))
            0:       return 64'hffff_ffff_ffff_f000 | 64'($urandom_range(0, 4095));
            1:       return 64'($urandom_range(0, 4095));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic issue_instr(logic [31:0] w, logic [63:0] pc);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            instr_valid <= 1'b0;
            @(posedge clk);
        end
        instr.instr_word <= w;
        instr.pc <= pc;
        instr_valid <= 1'b1;
        do
            @(posedge clk);
        while (!instr_ready);
        pending_results.push_back(decode_instr(w, pc));
        beats_sent++;
    endtask

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("mismatch at result %0d, %s: got %h expected %h",
                 results_checked, what, got, want);
    endtask

    task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    // receiver: random stalls, a steady mode and a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (steady)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(0, 99) >= 28);
    end

    always @(posedge clk)
    begin : check_results
        a64ic_pkg::out_beat_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("result with nothing pending, class",
                              64'(result.op_class), 64'h0);
            else
            begin
                want = pending_results.pop_front();
                compare_field("op_class", 64'(result.op_class), 64'(want.op_class));
                compare_field("target_addr", result.target_addr, want.target_addr);
                compare_field("cond_code", 64'(result.cond_code), 64'(want.cond_code));
                compare_field("reg_kind", 64'(result.reg_kind), 64'(want.reg_kind));
                compare_field("reg_primary", 64'(result.reg_primary),
                              64'(want.reg_primary));
                compare_field("reg_second", 64'(result.reg_second), 64'(want.reg_second));
                compare_field("reg_third", 64'(result.reg_third), 64'(want.reg_third));
                compare_field("reg_fourth", 64'(result.reg_fourth), 64'(want.reg_fourth));
                compare_field("bit_index", 64'(result.bit_index), 64'(want.bit_index));
                compare_field("imm_value", 64'(result.imm_value), 64'(want.imm_value));
                compare_field("mem_size_code", 64'(result.mem_size_code),
                              64'(want.mem_size_code));
                compare_field("next_pc", result.next_pc, want.next_pc);
                class_hits[want.op_class]++;
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        if ((instr_valid && instr_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed();
        issue_instr(32'h15ff_ffff, 64'hffff_ffff_ffff_fffc);
        issue_instr(32'h9600_0000, 64'h0);
        issue_instr(32'h5480_0000, 64'h1000);
        issue_instr(32'h547f_ffef, 64'h8000_0000_0000_0000);
        issue_instr(32'h3400_0000, 64'h40);
        issue_instr(32'hb5ff_ffff, 64'h10);
        issue_instr(32'h3600_0005, 64'hffff_ffff_ffff_fff0);
        issue_instr(32'hb7ff_ffff, 64'h20);
        issue_instr(32'hd61f_0000, 64'h100);
        issue_instr(32'hd63f_03e0, 64'h104);
        issue_instr(32'hd65f_03c0, 64'h108);
        issue_instr(32'hd67f_03e0, 64'h10c);
        issue_instr(32'h707f_ffff, 64'hffff_ffff_fff0_0000);
        issue_instr(32'h9080_0003, 64'h0000_1234_5678_9abc);
        issue_instr(32'h1800_0005, 64'h2000);
        issue_instr(32'h58ff_ffff, 64'h40);
        issue_instr(32'h9800_0000, 64'h3000);
        issue_instr(32'hd800_0000, 64'h3004);
        issue_instr(32'h1c00_0001, 64'h4000);
        issue_instr(32'h5c80_0002, 64'h4004);
        issue_instr(32'h9c7f_ffe3, 64'hffff_ffff_ffff_fff8);
        issue_instr(32'hdc00_0000, 64'h4008);
        issue_instr(32'hd53b_d05f, 64'h5000);
        issue_instr(32'hd51b_d040, 64'h5004);
        issue_instr(32'hd41f_ffe1, 64'h5008);
        issue_instr(32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
        issue_instr(32'h0000_0000, 64'h0);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (150) issue_instr(shaped_word(), shaped_pc());
        steady = 1'b0;
    endtask

    task automatic test_output_hold();
        steady = 1'b1;
        hold_request = 1'b1;
        repeat (100) issue_instr(shaped_word(), shaped_pc());
        steady = 1'b0;
    endtask

    task automatic test_random_mix();
        repeat (1680) issue_instr(shaped_word(), shaped_pc());
    endtask

    initial
    begin
        int classes_seen;
        classes_seen = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_to_back();
        test_output_hold();
        test_random_mix();

        instr_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        for (int i = 0; i < 32; i++)
            if (class_hits[i] != 0)
                classes_seen++;
        $display("summary: %0d instruction beats sent, %0d results compared, %0d classes seen",
                 beats_sent, results_checked, classes_seen);
        $display("summary: edge encodings, random and near-miss words, full rate, output hold");
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/a64ic_pkg.sv
rtl/a64ic_front.sv
rtl/a64ic_queue.sv
rtl/a64ic_back.sv
rtl/a64_instruction_classifier_top.sv
tb/tb.sv
